FILE: rtl/core/nrf_pkg.sv
// Shared types and constants of the necklace representative filter.
`default_nettype none

package nrf_pkg;

  localparam int CFG_W   = 5;   // width of the word_width register
  localparam int WORD_W  = 16;  // width of the candidate and word fields
  localparam int EPOCH_W = 8;   // width of the pass tag held in each map entry

  localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd8;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 5'd2;

  typedef struct packed {
    logic load;       // capture the input beat
    logic epoch_inc;  // open a new pass by advancing the tag
    logic clr_init;   // restart the clearing sweep and reset the tag
    logic clr_step;   // clear one map entry
    logic rd_cand;    // read the map entry of the candidate
    logic chk;        // evaluate the read data
    logic mark_step;  // one rotation step
    logic emit;       // load the output register
  } nrf_cmd_t;

  typedef struct packed {
    logic pass;       // captured beat starts a pass
    logic epoch_max;  // tag is about to wrap
    logic clr_last;   // sweep is at its final entry
    logic seen;       // candidate entry carries the current tag
    logic mark_done;  // rotation reached the word or the width
    logic out_free;   // output register can take a result
  } nrf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/nrf_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module nrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/nrf_ctrl.sv
// Control state machine of the necklace representative filter.
`default_nettype none

module nrf_ctrl
  import nrf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire nrf_sts_t sts,
  output nrf_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend;
  logic       pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = pend ? S_READ : S_IDLE;
          pend_next  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.pass && sts.epoch_max) begin
          // The tag would wrap: wipe the map, then look the word up.
          cmd.clr_init = 1'b1;
          pend_next    = 1'b1;
          state_next   = S_CLEAR;
        end else begin
          cmd.epoch_inc = sts.pass;
          cmd.rd_cand   = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_READ: begin
        cmd.rd_cand = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk    = 1'b1;
        state_next = sts.seen ? S_DONE : S_MARK;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/nrf_dp.sv
// Datapath of the necklace representative filter: seen map, rotation and output register.
`default_nettype none

module nrf_dp
  import nrf_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [WORD_W-1:0] candidate,
  input  wire logic              pass_start,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic      [WORD_W-1:0] word,
  output logic                   is_representative,
  input  wire nrf_cmd_t          cmd,
  output nrf_sts_t               sts
);

  localparam int AW    = MAX_WIDTH;
  localparam int DEPTH = 1 << MAX_WIDTH;

  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   eff_w;
  logic [AW-1:0]      mask;
  logic [AW-1:0]      topsel;
  logic [AW-1:0]      cand_r;
  logic [AW-1:0]      rot;
  logic [AW-1:0]      rot_next;
  logic [CFG_W-1:0]   k;
  logic               pass_r;
  logic               rep;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      clr_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_data;
    end
  end

  always_comb begin
    if (width_r < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
  end

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i]   = (CFG_W'(i) < eff_w);
      topsel[i] = (CFG_W'(i + 1) == eff_w);
    end
  end

  // Rotate left by one inside the configured width.
  assign rot_next = ((rot << 1) & mask) | AW'(|(rot & topsel));

  assign sts.mark_done = (k == eff_w) || (rot_next == cand_r);
  assign sts.pass      = pass_r;
  assign sts.epoch_max = &epoch;
  assign sts.clr_last  = &clr_addr;
  assign sts.seen      = (ram_rdata == epoch);
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r <= AW'(candidate) & mask;
      rot    <= AW'(candidate) & mask;
      pass_r <= pass_start;
      k      <= CFG_W'(1);
    end else if (cmd.mark_step && !sts.mark_done) begin
      rot <= rot_next;
      k   <= k + CFG_W'(1);
    end
    if (cmd.chk) begin
      rep <= !sts.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= EPOCH_W'(1);
      clr_addr <= '0;
    end else begin
      if (cmd.clr_init) begin
        epoch    <= EPOCH_W'(1);
        clr_addr <= '0;
      end else begin
        if (cmd.epoch_inc) begin
          epoch <= epoch + EPOCH_W'(1);
        end
        if (cmd.clr_step) begin
          clr_addr <= clr_addr + AW'(1);
        end
      end
    end
  end

  always_comb begin
    ram_we    = cmd.clr_step || (cmd.mark_step && !sts.mark_done);
    ram_wdata = cmd.clr_step ? '0 : epoch;
    priority if (cmd.clr_step) begin
      ram_addr = clr_addr;
    end else if (cmd.mark_step) begin
      ram_addr = rot_next;
    end else begin
      ram_addr = cand_r;
    end
  end

  nrf_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word              <= WORD_W'(cand_r);
      is_representative <= rep;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/necklace_representative_filter.sv
// Top level of the necklace representative filter.
// The filter takes candidate words, masks them to the configured width (word_width, held
// to the range 2..MAX_WIDTH, reset value 8) and reports each one with a flag that is set
// when the word is not yet marked in the current pass; the rotations of such a word other
// than the word itself are then marked in a seen map of 2**MAX_WIDTH entries.
// A beat with pass_start set empties the map before its word is looked up. Items are
// handled one at a time: a word that is already marked goes from its input beat through
// the start, check and done states to the output register, and a new representative also
// passes the mark state, which steps through its rotations one at a time because the map
// sits in one single-port memory (one write per rotation other than the word itself and a
// final step that sees the rotation end). The done state waits while a stalled result
// holds the output register; input is free again in the cycle after the result is loaded.
// The map stores a small pass tag per entry rather than a single bit, so starting a pass
// normally costs nothing. After reset, and once every 255 passes when the tag wraps, the
// block sweeps the whole map, one entry a cycle, and holds off input while it does; a
// wrap also adds the sweep to the time its item takes.
// The output sits in its own register, so the next input beat is taken while a result
// still waits to be collected. word_width is written through cfg_we and cfg_data and
// must only change while the block is idle.
`default_nettype none

module necklace_representative_filter
  import nrf_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] candidate,
  input  wire logic              pass_start,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] word,
  output logic                   is_representative
);

  // Commands from the controller and status back from the datapath.
  nrf_cmd_t cmd;
  nrf_sts_t sts;

  nrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrf_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .candidate         (candidate),
    .pass_start        (pass_start),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .word              (word),
    .is_representative (is_representative),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

FILE: rtl/core/nrf_checker.sv
// Port-level checker of the necklace representative filter and its bind.
`default_nettype none

module nrf_checker
  import nrf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [WORD_W-1:0] word,
  input wire logic              is_representative
);

  // The map sweep after reset holds off input.
  a_reset_sweep: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second input beat taken while an item is in work");

  // A result cannot appear in the cycle right after its input beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && !in_stall))
    else $error("result appeared too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(word) && $stable(is_representative)))
    else $error("stalled result changed");

endmodule

bind necklace_representative_filter nrf_checker u_nrf_checker (.*);

`default_nettype wire
